// ===== rtl/lba_pkg.sv =====
// shared types, codes and constants for the led level bar animator
// no dependencies; used by led_level_bar_animator
package lba_pkg;

    localparam int BAR_WIDTH     = 8;
    localparam int NOBODY_CODE   = 15;
    localparam int BLINK_HALF_MS = 250;

    localparam int MASK_W  = 8;
    localparam int STEP_W  = 5;
    localparam int LEVEL_W = 4;
    localparam int MS_W    = 32;
    localparam int SPAN_W  = 16;
    localparam int PADDR_W = 5;

    // item codes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_SHOW    = 3'd1;
    localparam logic [2:0] MODE_OPEN    = 3'd2;
    localparam logic [2:0] MODE_PICK    = 3'd3;
    localparam logic [2:0] MODE_ACCEPT  = 3'd4;
    localparam logic [2:0] MODE_DISMISS = 3'd5;
    localparam logic [2:0] MODE_CLOSE   = 3'd6;
    localparam logic [2:0] MODE_DEFER   = 3'd7;

    // bar phases
    localparam logic [2:0] PH_OFF     = 3'd0;
    localparam logic [2:0] PH_IN      = 3'd1;
    localparam logic [2:0] PH_HOLD    = 3'd2;
    localparam logic [2:0] PH_CONFIRM = 3'd3;
    localparam logic [2:0] PH_OUT     = 3'd4;

    // register indexes
    localparam logic [2:0] REG_READOUT_SPAN  = 3'd0;
    localparam logic [2:0] REG_ARM_SPAN      = 3'd1;
    localparam logic [2:0] REG_FILL_STEP_MS  = 3'd2;
    localparam logic [2:0] REG_EXIT_DWELL_MS = 3'd3;
    localparam logic [2:0] REG_FLASH_HALF_MS = 3'd4;
    localparam logic [2:0] REG_FLASH_COUNT   = 3'd5;

    localparam logic [15:0] RST_READOUT_SPAN  = 16'd1500;
    localparam logic [15:0] RST_ARM_SPAN      = 16'd4000;
    localparam logic [15:0] RST_FILL_STEP_MS  = 16'd60;
    localparam logic [15:0] RST_EXIT_DWELL_MS = 16'd150;
    localparam logic [15:0] RST_FLASH_HALF_MS = 16'd120;
    localparam logic [3:0]  RST_FLASH_COUNT   = 4'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  who;
        logic [3:0]  want;
        logic [15:0] defer_ms;
    } lba_in_t;

    typedef struct packed {
        logic [7:0] bar_mask;
        logic       is_armed;
        logic [3:0] owner_id;
        logic       is_showing;
        logic       blink_on;
    } lba_out_t;

    // lowest n lamps lit, saturating at the mask width
    function automatic logic [MASK_W-1:0] lamps_upto(input logic [5:0] n);
        logic [MASK_W-1:0] res;
        if (n >= 6'(MASK_W))
        begin
            res = '1;
        end
        else
        begin
            res = (MASK_W'(1) << n) - MASK_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/led_level_bar_animator.sv =====
// led level bar animator: phase sequencer, hold timing and blink tracking
// depends on lba_pkg
// an accepted item waits in the input register; its result is then registered
// throughput: one item per cycle unless out_ready stalls the result register,
// set by the single next-state pass between the input and result registers
// reset: bar off, all timers and counters zero, config registers at defaults
// elapsed times are kept as running counters, so no divider is needed for blink
module led_level_bar_animator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lba_pkg::lba_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lba_pkg::lba_out_t             out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lba_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [15:0] BLINK_LAST = 16'(lba_pkg::BLINK_HALF_MS - 1);
    localparam logic [5:0]  BAR_W6     = 6'(lba_pkg::BAR_WIDTH);
    localparam logic [3:0]  BAR_W4     = 4'(lba_pkg::BAR_WIDTH);
    localparam logic [3:0]  NOBODY     = 4'(lba_pkg::NOBODY_CODE);

    // configuration
    logic [15:0] readout_span_reg;
    logic [15:0] arm_span_reg;
    logic [15:0] fill_step_reg;
    logic [15:0] exit_dwell_reg;
    logic [15:0] flash_half_reg;
    logic [3:0]  flash_count_reg;
    logic [2:0]  reg_index;
    logic        cfg_write;

    // pipeline
    logic             s1_valid_reg;
    lba_pkg::lba_in_t s1_item_reg;
    logic             out_valid_reg;
    lba_pkg::lba_out_t out_item_reg;
    logic             advance;

    // bar state
    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] frame_el_reg, frame_el_next;
    logic [31:0] hold_el_reg, hold_el_next;
    logic [15:0] hold_len_reg, hold_len_next;
    logic [3:0]  owner_reg, owner_next;
    logic [3:0]  level_reg, level_next;
    logic        armed_reg, armed_next;
    logic [15:0] blink_rem_reg, blink_rem_next;
    logic        blink_par_reg, blink_par_next;

    // scratch
    logic [31:0] frame_tick;
    logic [31:0] hold_tick;
    logic [15:0] rem_tick;
    logic        par_tick;
    logic [4:0]  step_inc;
    logic        last_frame;
    logic [15:0] out_thresh;
    logic [15:0] span_sel;
    logic [3:0]  want_sat;
    logic        showing;
    logic        leave;
    logic        hold_restart;
    logic [31:0] hold_left;
    logic [7:0]  lit;
    logic [7:0]  mask_next;

    assign pready    = 1'b1;
    assign reg_index = paddr[lba_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readout_span_reg <= lba_pkg::RST_READOUT_SPAN;
            arm_span_reg     <= lba_pkg::RST_ARM_SPAN;
            fill_step_reg    <= lba_pkg::RST_FILL_STEP_MS;
            exit_dwell_reg   <= lba_pkg::RST_EXIT_DWELL_MS;
            flash_half_reg   <= lba_pkg::RST_FLASH_HALF_MS;
            flash_count_reg  <= lba_pkg::RST_FLASH_COUNT;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                lba_pkg::REG_READOUT_SPAN:  readout_span_reg <= pwdata[15:0];
                lba_pkg::REG_ARM_SPAN:      arm_span_reg     <= pwdata[15:0];
                lba_pkg::REG_FILL_STEP_MS:  fill_step_reg    <= pwdata[15:0];
                lba_pkg::REG_EXIT_DWELL_MS: exit_dwell_reg   <= pwdata[15:0];
                lba_pkg::REG_FLASH_HALF_MS: flash_half_reg   <= pwdata[15:0];
                lba_pkg::REG_FLASH_COUNT:   flash_count_reg  <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            lba_pkg::REG_READOUT_SPAN:  prdata = {16'd0, readout_span_reg};
            lba_pkg::REG_ARM_SPAN:      prdata = {16'd0, arm_span_reg};
            lba_pkg::REG_FILL_STEP_MS:  prdata = {16'd0, fill_step_reg};
            lba_pkg::REG_EXIT_DWELL_MS: prdata = {16'd0, exit_dwell_reg};
            lba_pkg::REG_FLASH_HALF_MS: prdata = {16'd0, flash_half_reg};
            lba_pkg::REG_FLASH_COUNT:   prdata = {28'd0, flash_count_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    // next state for the item in the input register
    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        frame_el_next  = frame_el_reg;
        hold_el_next   = hold_el_reg;
        hold_len_next  = hold_len_reg;
        owner_next     = owner_reg;
        level_next     = level_reg;
        armed_next     = armed_reg;
        blink_rem_next = blink_rem_reg;
        blink_par_next = blink_par_reg;

        frame_tick = frame_el_reg + 32'd1;
        hold_tick  = hold_el_reg + 32'd1;
        if (hold_el_reg == '1)
        begin
            rem_tick = 16'd0;
            par_tick = 1'b0;
        end
        else if (blink_rem_reg == BLINK_LAST)
        begin
            rem_tick = 16'd0;
            par_tick = !blink_par_reg;
        end
        else
        begin
            rem_tick = blink_rem_reg + 16'd1;
            par_tick = blink_par_reg;
        end

        step_inc   = step_reg + 5'd1;
        last_frame = (level_reg == 4'd0) || (({1'b0, step_reg} + 6'd1) >= BAR_W6);
        out_thresh = last_frame ? exit_dwell_reg : fill_step_reg;
        showing    = (phase_reg == lba_pkg::PH_IN) || (phase_reg == lba_pkg::PH_HOLD);
        span_sel   = (s1_item_reg.mode == lba_pkg::MODE_OPEN) ? arm_span_reg
                                                             : readout_span_reg;
        want_sat   = (s1_item_reg.want > BAR_W4) ? BAR_W4 : s1_item_reg.want;
        hold_left  = (hold_el_reg < {16'd0, hold_len_reg})
                   ? ({16'd0, hold_len_reg} - hold_el_reg) : 32'd0;
        leave        = 1'b0;
        hold_restart = 1'b0;

        case (s1_item_reg.mode)
            lba_pkg::MODE_TICK:
            begin
                frame_el_next  = frame_tick;
                hold_el_next   = hold_tick;
                blink_rem_next = rem_tick;
                blink_par_next = par_tick;
                case (phase_reg)
                    lba_pkg::PH_IN:
                    begin
                        if (frame_tick >= {16'd0, fill_step_reg})
                        begin
                            frame_el_next = 32'd0;
                            step_next     = step_inc;
                            if (step_inc >= {1'b0, level_reg})
                            begin
                                phase_next   = lba_pkg::PH_HOLD;
                                hold_restart = 1'b1;
                            end
                        end
                    end
                    lba_pkg::PH_HOLD:
                    begin
                        if (hold_tick >= {16'd0, hold_len_reg})
                        begin
                            leave = 1'b1;
                        end
                    end
                    lba_pkg::PH_CONFIRM:
                    begin
                        if (frame_tick >= {16'd0, flash_half_reg})
                        begin
                            frame_el_next = 32'd0;
                            step_next     = step_inc;
                            if (step_inc >= {flash_count_reg, 1'b0})
                            begin
                                phase_next = lba_pkg::PH_OFF;
                                owner_next = NOBODY;
                            end
                        end
                    end
                    lba_pkg::PH_OUT:
                    begin
                        if (frame_tick >= {16'd0, out_thresh})
                        begin
                            frame_el_next = 32'd0;
                            step_next     = step_inc;
                            if ({1'b0, step_inc} >= BAR_W6)
                            begin
                                phase_next = lba_pkg::PH_OFF;
                                owner_next = NOBODY;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lba_pkg::MODE_SHOW, lba_pkg::MODE_OPEN:
            begin
                owner_next    = s1_item_reg.who;
                level_next    = want_sat;
                hold_len_next = span_sel;
                armed_next    = (s1_item_reg.mode == lba_pkg::MODE_OPEN);
                if (showing)
                begin
                    hold_restart = 1'b1;
                end
                else
                begin
                    phase_next    = lba_pkg::PH_IN;
                    step_next     = 5'd1;
                    frame_el_next = 32'd0;
                end
            end
            lba_pkg::MODE_PICK:
            begin
                if (armed_reg && (s1_item_reg.want != 4'd0) && (s1_item_reg.want <= BAR_W4))
                begin
                    level_next    = s1_item_reg.want;
                    armed_next    = 1'b0;
                    phase_next    = lba_pkg::PH_CONFIRM;
                    step_next     = 5'd0;
                    frame_el_next = 32'd0;
                end
            end
            lba_pkg::MODE_ACCEPT:
            begin
                leave = armed_reg;
            end
            lba_pkg::MODE_DISMISS:
            begin
                leave = 1'b1;
            end
            lba_pkg::MODE_CLOSE:
            begin
                if (owner_reg == s1_item_reg.who)
                begin
                    phase_next = lba_pkg::PH_OFF;
                    armed_next = 1'b0;
                    owner_next = NOBODY;
                end
            end
            lba_pkg::MODE_DEFER:
            begin
                if (phase_reg == lba_pkg::PH_IN)
                begin
                    if (hold_len_reg < s1_item_reg.defer_ms)
                    begin
                        hold_len_next = s1_item_reg.defer_ms;
                    end
                end
                else if (phase_reg == lba_pkg::PH_HOLD)
                begin
                    if (hold_left < {16'd0, s1_item_reg.defer_ms})
                    begin
                        hold_restart  = 1'b1;
                        hold_len_next = s1_item_reg.defer_ms;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (leave)
        begin
            armed_next = 1'b0;
            if ((phase_reg != lba_pkg::PH_OFF) && (phase_reg != lba_pkg::PH_OUT))
            begin
                phase_next    = lba_pkg::PH_OUT;
                step_next     = 5'd1;
                frame_el_next = 32'd0;
            end
        end

        if (hold_restart)
        begin
            hold_el_next   = 32'd0;
            blink_rem_next = 16'd0;
            blink_par_next = 1'b0;
        end
    end

    // lamp mask after the item
    always_comb
    begin
        lit = lba_pkg::lamps_upto({2'd0, level_next});
        case (phase_next)
            lba_pkg::PH_IN:      mask_next = lit & lba_pkg::lamps_upto({1'b0, step_next});
            lba_pkg::PH_HOLD:    mask_next = lit;
            lba_pkg::PH_CONFIRM: mask_next = step_next[0] ? 8'd0 : lit;
            lba_pkg::PH_OUT:
            begin
                if ({1'b0, step_next} >= BAR_W6)
                begin
                    mask_next = 8'd0;
                end
                else
                begin
                    mask_next = (lit << step_next)
                              & lba_pkg::lamps_upto(BAR_W6);
                end
            end
            default:             mask_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lba_pkg::PH_OFF;
            step_reg      <= 5'd0;
            frame_el_reg  <= 32'd0;
            hold_el_reg   <= 32'd0;
            hold_len_reg  <= 16'd0;
            owner_reg     <= 4'd0;
            level_reg     <= 4'd0;
            armed_reg     <= 1'b0;
            blink_rem_reg <= 16'd0;
            blink_par_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            frame_el_reg  <= frame_el_next;
            hold_el_reg   <= hold_el_next;
            hold_len_reg  <= hold_len_next;
            owner_reg     <= owner_next;
            level_reg     <= level_next;
            armed_reg     <= armed_next;
            blink_rem_reg <= blink_rem_next;
            blink_par_reg <= blink_par_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.bar_mask   <= mask_next;
            out_item_reg.is_armed   <= armed_next;
            out_item_reg.owner_id   <= owner_next;
            out_item_reg.is_showing <= (phase_next == lba_pkg::PH_IN)
                                    || (phase_next == lba_pkg::PH_HOLD);
            out_item_reg.blink_on   <= !blink_par_next;
        end
    end

endmodule

// ===== bench/lba_checker.sv =====
// checker for the led level bar animator: watches the item, result and register ports,
// predicts every result from its own copy of the bar state and compares field by field
// depends on lba_pkg
`timescale 1ns / 100ps

module lba_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  lba_pkg::lba_in_t            in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  lba_pkg::lba_out_t           out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [lba_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          mismatches,
    output int                          outstanding
);

    localparam logic [31:0] BLINK_MS = lba_pkg::BLINK_HALF_MS;
    localparam logic [31:0] FULL_BAR = (32'd1 << lba_pkg::BAR_WIDTH) - 32'd1;

    logic [15:0] cfg_readout;
    logic [15:0] cfg_arm;
    logic [15:0] cfg_frame;
    logic [15:0] cfg_dwell;
    logic [15:0] cfg_flash_half;
    logic [3:0]  cfg_flashes;

    logic [2:0]  bar_state;
    logic [4:0]  frame_idx;
    logic [31:0] now_count;
    logic [31:0] frame_origin;
    logic [31:0] hold_origin;
    logic [15:0] hold_ms;
    logic [3:0]  holder;
    logic [3:0]  lit_level;
    logic        choice_open;

    lba_pkg::lba_out_t due_readouts[$];
    int                readout_no;

    task automatic report_fault(input string what);
        if (mismatches < 100)
            $display("mismatch: %s", what);
        mismatches++;
    endtask

    function automatic logic [31:0] low_lamps(input logic [5:0] n);
        return (n >= 6'd32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
    endfunction

    function automatic logic [31:0] slid_lamps(input logic [5:0] shift);
        return (shift >= 6'd32) ? 32'd0 : (low_lamps(6'(lit_level)) << shift) & FULL_BAR;
    endfunction

    function automatic logic showing_now();
        return bar_state == lba_pkg::PH_IN || bar_state == lba_pkg::PH_HOLD;
    endfunction

    task automatic start_display(input logic [3:0] person, input logic [3:0] level,
                                 input logic [15:0] span);
        holder    = person;
        lit_level = (level > lba_pkg::BAR_WIDTH) ? 4'(lba_pkg::BAR_WIDTH) : level;
        hold_ms   = span;
        if (showing_now())
            hold_origin = now_count;
        else
        begin
            bar_state    = lba_pkg::PH_IN;
            frame_idx    = 5'd1;
            frame_origin = now_count;
        end
    endtask

    task automatic start_exit();
        choice_open = 1'b0;
        if (bar_state != lba_pkg::PH_OFF && bar_state != lba_pkg::PH_OUT)
        begin
            bar_state    = lba_pkg::PH_OUT;
            frame_idx    = 5'd1;
            frame_origin = now_count;
        end
    endtask

    task automatic advance_bar(input lba_pkg::lba_in_t item, output lba_pkg::lba_out_t res);
        logic [31:0] since;
        logic [31:0] left;
        logic [31:0] lit;
        case (item.mode)
            lba_pkg::MODE_TICK:
            begin
                now_count = now_count + 32'd1;
                since = now_count - frame_origin;
                case (bar_state)
                    lba_pkg::PH_IN:
                    begin
                        if (since >= cfg_frame)
                        begin
                            frame_origin = now_count;
                            frame_idx    = frame_idx + 5'd1;
                            if (frame_idx >= lit_level)
                            begin
                                bar_state   = lba_pkg::PH_HOLD;
                                hold_origin = now_count;
                            end
                        end
                    end
                    lba_pkg::PH_HOLD:
                    begin
                        if ((now_count - hold_origin) >= hold_ms)
                            start_exit();
                    end
                    lba_pkg::PH_CONFIRM:
                    begin
                        if (since >= cfg_flash_half)
                        begin
                            frame_origin = now_count;
                            frame_idx    = frame_idx + 5'd1;
                            if (frame_idx >= {cfg_flashes, 1'b0})
                            begin
                                bar_state = lba_pkg::PH_OFF;
                                holder    = 4'(lba_pkg::NOBODY_CODE);
                            end
                        end
                    end
                    lba_pkg::PH_OUT:
                    begin
                        if (since >= ((slid_lamps(6'(frame_idx) + 6'd1) == 32'd0) ?
                                      cfg_dwell : cfg_frame))
                        begin
                            frame_origin = now_count;
                            frame_idx    = frame_idx + 5'd1;
                            if (frame_idx >= lba_pkg::BAR_WIDTH)
                            begin
                                bar_state = lba_pkg::PH_OFF;
                                holder    = 4'(lba_pkg::NOBODY_CODE);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            lba_pkg::MODE_SHOW:
            begin
                start_display(item.who, item.want, cfg_readout);
                choice_open = 1'b0;
            end
            lba_pkg::MODE_OPEN:
            begin
                start_display(item.who, item.want, cfg_arm);
                choice_open = 1'b1;
            end
            lba_pkg::MODE_PICK:
            begin
                if (choice_open && item.want != 4'd0 && item.want <= lba_pkg::BAR_WIDTH)
                begin
                    lit_level    = item.want;
                    choice_open  = 1'b0;
                    bar_state    = lba_pkg::PH_CONFIRM;
                    frame_idx    = 5'd0;
                    frame_origin = now_count;
                end
            end
            lba_pkg::MODE_ACCEPT:
            begin
                if (choice_open)
                    start_exit();
            end
            lba_pkg::MODE_DISMISS:
            begin
                start_exit();
            end
            lba_pkg::MODE_CLOSE:
            begin
                if (holder == item.who)
                begin
                    bar_state   = lba_pkg::PH_OFF;
                    choice_open = 1'b0;
                    holder      = 4'(lba_pkg::NOBODY_CODE);
                end
            end
            default:
            begin
                if (bar_state == lba_pkg::PH_IN)
                begin
                    if (hold_ms < item.defer_ms)
                        hold_ms = item.defer_ms;
                end
                else if (bar_state == lba_pkg::PH_HOLD)
                begin
                    since = now_count - hold_origin;
                    left  = (since < hold_ms) ? hold_ms - since : 32'd0;
                    if (left < item.defer_ms)
                    begin
                        hold_origin = now_count;
                        hold_ms     = item.defer_ms;
                    end
                end
            end
        endcase

        lit = low_lamps(6'(lit_level));
        case (bar_state)
            lba_pkg::PH_IN:      res.bar_mask = 8'(lit & low_lamps(6'(frame_idx)));
            lba_pkg::PH_HOLD:    res.bar_mask = 8'(lit);
            lba_pkg::PH_CONFIRM: res.bar_mask = frame_idx[0] ? 8'd0 : 8'(lit);
            lba_pkg::PH_OUT:     res.bar_mask = 8'(slid_lamps(6'(frame_idx)));
            default:             res.bar_mask = 8'd0;
        endcase
        res.is_armed   = choice_open;
        res.owner_id   = holder;
        res.is_showing = showing_now();
        res.blink_on   = (((now_count - hold_origin) / BLINK_MS) % 32'd2) == 32'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lba_pkg::lba_out_t wanted;
        lba_pkg::lba_out_t fresh;
        if (!rst_n)
        begin
            cfg_readout    = lba_pkg::RST_READOUT_SPAN;
            cfg_arm        = lba_pkg::RST_ARM_SPAN;
            cfg_frame      = lba_pkg::RST_FILL_STEP_MS;
            cfg_dwell      = lba_pkg::RST_EXIT_DWELL_MS;
            cfg_flash_half = lba_pkg::RST_FLASH_HALF_MS;
            cfg_flashes    = lba_pkg::RST_FLASH_COUNT;
            bar_state      = lba_pkg::PH_OFF;
            frame_idx      = 5'd0;
            now_count      = 32'd0;
            frame_origin   = 32'd0;
            hold_origin    = 32'd0;
            hold_ms        = 16'd0;
            holder         = 4'd0;
            lit_level      = 4'd0;
            choice_open    = 1'b0;
            readout_no     = 0;
            mismatches     = 0;
            due_readouts.delete();
            outstanding    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                readout_no++;
                if (due_readouts.size() == 0)
                    report_fault($sformatf("readout %0d arrived with none expected",
                                           readout_no));
                else
                begin
                    wanted = due_readouts.pop_front();
                    if (out_data.bar_mask !== wanted.bar_mask)
                        report_fault($sformatf("readout %0d bar_mask %h, expected %h",
                                               readout_no, out_data.bar_mask,
                                               wanted.bar_mask));
                    if (out_data.is_armed !== wanted.is_armed)
                        report_fault($sformatf("readout %0d is_armed %b, expected %b",
                                               readout_no, out_data.is_armed,
                                               wanted.is_armed));
                    if (out_data.owner_id !== wanted.owner_id)
                        report_fault($sformatf("readout %0d owner_id %0d, expected %0d",
                                               readout_no, out_data.owner_id,
                                               wanted.owner_id));
                    if (out_data.is_showing !== wanted.is_showing)
                        report_fault($sformatf("readout %0d is_showing %b, expected %b",
                                               readout_no, out_data.is_showing,
                                               wanted.is_showing));
                    if (out_data.blink_on !== wanted.blink_on)
                        report_fault($sformatf("readout %0d blink_on %b, expected %b",
                                               readout_no, out_data.blink_on,
                                               wanted.blink_on));
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[lba_pkg::PADDR_W-1:2])
                    lba_pkg::REG_READOUT_SPAN:  cfg_readout    = pwdata[15:0];
                    lba_pkg::REG_ARM_SPAN:      cfg_arm        = pwdata[15:0];
                    lba_pkg::REG_FILL_STEP_MS:  cfg_frame      = pwdata[15:0];
                    lba_pkg::REG_EXIT_DWELL_MS: cfg_dwell      = pwdata[15:0];
                    lba_pkg::REG_FLASH_HALF_MS: cfg_flash_half = pwdata[15:0];
                    lba_pkg::REG_FLASH_COUNT:   cfg_flashes    = pwdata[3:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && in_ready)
            begin
                advance_bar(in_data, fresh);
                due_readouts.push_back(fresh);
            end
            outstanding = due_readouts.size();
        end
    end

endmodule

// ===== bench/led_level_bar_animator_test.sv =====
// top of the led level bar animator bench: clock, reset, register writes and item stimulus
// with random idling on both sides; results are judged by lba_checker
// depends on lba_pkg, led_level_bar_animator and lba_checker
`timescale 1ns / 100ps

module led_level_bar_animator_test;

    localparam int CYCLE_LIMIT = 200000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    lba_pkg::lba_in_t            in_data;
    logic                        out_valid;
    logic                        out_ready;
    lba_pkg::lba_out_t           out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lba_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    int                          mismatches;
    int                          outstanding;
    int                          items_sent;
    int                          cycle_count;
    logic                        calm;

    led_level_bar_animator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lba_checker bar_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic lba_pkg::lba_in_t compose(input logic [2:0] mode,
                                                 input logic [3:0] who,
                                                 input logic [3:0] want,
                                                 input logic [15:0] span);
        lba_pkg::lba_in_t item;
        item.mode     = mode;
        item.who      = who;
        item.want     = want;
        item.defer_ms = span;
        return item;
    endfunction

    task automatic push_item(input lba_pkg::lba_in_t item);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            push_item(compose(lba_pkg::MODE_TICK, 4'($urandom), 4'($urandom),
                              16'($urandom)));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] readout, input logic [15:0] arm,
                                 input logic [15:0] frame, input logic [15:0] dwell,
                                 input logic [15:0] flash_half, input logic [3:0] flashes);
        apb_write(lba_pkg::REG_READOUT_SPAN, readout);
        apb_write(lba_pkg::REG_ARM_SPAN, arm);
        apb_write(lba_pkg::REG_FILL_STEP_MS, frame);
        apb_write(lba_pkg::REG_EXIT_DWELL_MS, dwell);
        apb_write(lba_pkg::REG_FLASH_HALF_MS, flash_half);
        apb_write(lba_pkg::REG_FLASH_COUNT, {12'd0, flashes});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one display request, time, maybe a button event, more time; or one random item
    task automatic run_episode(input int burst_cap);
        int          pick;
        logic [3:0]  person;
        logic [3:0]  level;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            push_item(compose(3'($urandom_range(7)), 4'($urandom), 4'($urandom),
                              16'($urandom)));
            return;
        end
        person = 4'($urandom);
        level  = ($urandom_range(9) == 0) ? 4'($urandom)
                                          : 4'($urandom_range(1, lba_pkg::BAR_WIDTH));
        push_item(compose($urandom_range(1) ? lba_pkg::MODE_OPEN : lba_pkg::MODE_SHOW,
                          person, level, 16'($urandom)));
        send_ticks($urandom_range(burst_cap));
        case ($urandom_range(7))
            0, 1:
            begin
                level = ($urandom_range(4) == 0) ? 4'($urandom) :
                        4'($urandom_range(1, lba_pkg::BAR_WIDTH));
                push_item(compose(lba_pkg::MODE_PICK, 4'($urandom), level, 16'($urandom)));
            end
            2:
                push_item(compose(lba_pkg::MODE_ACCEPT, 4'($urandom), 4'($urandom),
                                  16'($urandom)));
            3:
                push_item(compose(lba_pkg::MODE_DISMISS, 4'($urandom), 4'($urandom),
                                  16'($urandom)));
            4:
                push_item(compose(lba_pkg::MODE_DEFER, 4'($urandom), 4'($urandom),
                                  $urandom_range(1) ? 16'($urandom_range(0, 3 * burst_cap))
                                                    : 16'($urandom)));
            5:
                push_item(compose(lba_pkg::MODE_CLOSE,
                                  ($urandom_range(3) == 0) ? 4'($urandom) : person,
                                  4'($urandom), 16'($urandom)));
            default:
            begin
            end
        endcase
        send_ticks($urandom_range(2 * burst_cap));
    endtask

    initial
    begin : stimulus
        int          ph;
        int          goal;
        int          quota;
        int          burst;
        logic [15:0] frame;
        bit          paused;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        calm        = 1'b0;
        items_sent  = 0;
        cycle_count = 0;
        paused      = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // event handling at reset settings
        push_item(compose(lba_pkg::MODE_TICK, 4'd0, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_DEFER, 4'd0, 4'd0, 16'hFFFF));
        push_item(compose(lba_pkg::MODE_PICK, 4'd0, 4'd3, 16'd0));
        push_item(compose(lba_pkg::MODE_ACCEPT, 4'd0, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_CLOSE, 4'd3, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_CLOSE, 4'd0, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_SHOW, 4'd2, 4'd15, 16'd0));
        push_item(compose(lba_pkg::MODE_TICK, 4'd0, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_DEFER, 4'd2, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_DEFER, 4'd2, 4'd0, 16'hFFFF));
        push_item(compose(lba_pkg::MODE_CLOSE, 4'd9, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_OPEN, 4'd2, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_PICK, 4'd2, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_PICK, 4'd2, 4'd9, 16'd0));
        push_item(compose(lba_pkg::MODE_PICK, 4'd2, 4'd8, 16'd0));
        push_item(compose(lba_pkg::MODE_TICK, 4'd0, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_OPEN, 4'd14, 4'd8, 16'd0));
        push_item(compose(lba_pkg::MODE_ACCEPT, 4'd14, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_TICK, 4'd0, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_SHOW, 4'd15, 4'd1, 16'd0));
        push_item(compose(lba_pkg::MODE_DISMISS, 4'd15, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_DISMISS, 4'd15, 4'd0, 16'd0));
        push_item(compose(lba_pkg::MODE_OPEN, 4'd0, 4'd4, 16'd0));
        push_item(compose(lba_pkg::MODE_CLOSE, 4'd0, 4'd0, 16'd0));
        wait_for_results();

        for (ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:
                begin
                    burst = 40;
                    quota = 250;
                end
                1:
                begin
                    load_settings(16'd6, 16'd15, 16'd1, 16'd3, 16'd2, 4'd2);
                    burst = 14;
                    quota = 200;
                end
                2:
                begin
                    load_settings(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 4'd1);
                    burst = 10;
                    quota = 200;
                end
                3:
                begin
                    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
                    burst = 6;
                    quota = 60;
                end
                default:
                begin
                    frame = 16'($urandom_range(1, 6));
                    load_settings(16'($urandom_range(0, 60)), 16'($urandom_range(0, 120)),
                                  frame, 16'($urandom_range(1, 10)),
                                  16'($urandom_range(1, 5)), 4'($urandom_range(1, 15)));
                    burst = 8 * frame + 4;
                    quota = 125;
                end
            endcase
            calm = (ph == 1);
            goal = items_sent + quota;
            while (items_sent < goal)
            begin
                if (ph == 4 && !paused && items_sent >= goal - 60)
                begin
                    wait_for_results();
                    paused = 1'b1;
                end
                run_episode(burst);
            end
            wait_for_results();
        end

        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== led_level_bar_animator.f =====
rtl/lba_pkg.sv
rtl/led_level_bar_animator.sv
bench/lba_checker.sv
bench/led_level_bar_animator_test.sv
